### design/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and round functions for the aes-128 encryptor
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RndW      = 4;

  typedef logic [127:0] blk_t;
  typedef logic [63:0]  half_t;

  typedef enum logic [0:0] {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] Rcon [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte n of a block sits at bits [127-8n -: 8]
  function automatic logic [7:0] get_byte(blk_t b, int unsigned n);
    get_byte = b[127 - 8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t sub_shift(blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4+r) -: 8] = Sbox[get_byte(s, ((c + r) % 4)*4 + r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix_columns(blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4+1);
      a2 = get_byte(s, c*4+2);
      a3 = get_byte(s, c*4+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(c*4)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[127 - 8*(c*4+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[127 - 8*(c*4+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[127 - 8*(c*4+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  // next round key from the previous one
  function automatic blk_t next_key(blk_t k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {Sbox[w3[23:16]], Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    t  = t ^ {rc, 24'h0};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

`default_nettype wire

### design/aes_if.sv
// ----------------------------------------------------------------------------
// aes_if
// valid/ready channels: data blocks and configuration writes
// ----------------------------------------------------------------------------
`default_nettype none

interface aes_blk_if;
  logic                valid;
  logic                ready;
  logic [63:0]         data_high;
  logic [63:0]         data_low;
  modport source (output valid, data_high, data_low, input ready);
  modport sink   (input valid, data_high, data_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// one pipeline stage: a cipher round plus the matching key expansion step
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          last_i,
  input  wire logic [7:0]    rcon_i,
  input  wire logic          valid_i,
  input  wire aes_pkg::blk_t state_i,
  input  wire aes_pkg::blk_t key_i,
  output logic               valid_o,
  output aes_pkg::blk_t      state_o,
  output aes_pkg::blk_t      key_o
);
  import aes_pkg::*;

  logic  valid_q;
  blk_t  state_q, key_q;
  blk_t  key_d, ss, state_d;

  always_comb begin
    key_d   = next_key(key_i, rcon_i);
    ss      = sub_shift(state_i);
    state_d = (last_i ? ss : mix_columns(ss)) ^ key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

`default_nettype wire

### design/aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top
// aes-128 encryptor, one round per pipeline stage, key carried alongside
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   data_high, data_low (plaintext)
// out_ch   out  data_high, data_low (ciphertext)
// cfg_ch   in   index, data (0 key_high, 1 key_low)
//
// pipeline: input add-key stage then ten round stages
// one block per cycle while the output is not stalled; the round stage limits the clock
// the key in use is sampled with each block as it enters
// a stall freezes the whole pipeline; ready follows the output stage
// reset clears the key registers and all valid bits
`default_nettype none

module aes128_block_encrypt_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aes_blk_if.sink   in_ch,
  aes_blk_if.source out_ch,
  aes_cfg_if.sink   cfg_ch
);
  import aes_pkg::*;

  localparam int unsigned Stages = NumRounds + 1;

  half_t key_high_q, key_low_q;
  logic  en;
  logic  v   [Stages+1];
  blk_t  st  [Stages+1];
  blk_t  ky  [Stages+1];
  logic  v0_q;
  blk_t  st0_q, ky0_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == 64'(CfgKeyHigh)) begin
        key_high_q <= cfg_ch.data;
      end else if (cfg_ch.index == 64'(CfgKeyLow)) begin
        key_low_q <= cfg_ch.data;
      end
    end
  end

  assign en          = !v[Stages] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_ch.valid) begin
      st0_q <= {in_ch.data_high, in_ch.data_low} ^ {key_high_q, key_low_q};
      ky0_q <= {key_high_q, key_low_q};
    end
  end

  assign v[1]  = v0_q;
  assign st[1] = st0_q;
  assign ky[1] = ky0_q;
  assign v[0]  = in_ch.valid;
  assign st[0] = '0;
  assign ky[0] = '0;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .last_i (g == NumRounds),
      .rcon_i (Rcon[g-1]),
      .valid_i(v[g]),
      .state_i(st[g]),
      .key_i  (ky[g]),
      .valid_o(v[g+1]),
      .state_o(st[g+1]),
      .key_o  (ky[g+1])
    );
  end

  assign out_ch.valid     = v[Stages];
  assign out_ch.data_high = st[Stages][127:64];
  assign out_ch.data_low  = st[Stages][63:0];

  logic unused_ok;
  assign unused_ok = v[0] ^ ^st[0] ^ ^ky[0] ^ ^ky[Stages];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data_high))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked while output empty");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> v0_q)
    else $error("accepted block lost at entry");

endmodule

`default_nettype wire

### verif/aes128_block_encrypt_top_tb.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top_tb
// drives plaintext blocks and key writes into the aes-128 encryptor and checks
// every ciphertext against an in-bench cipher or known vectors, with random stalls on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_encrypt_top_tb;
  import aes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 1750;
  localparam int unsigned Latency   = 11;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } pair_t;

  typedef struct {
    logic        is_key;
    cfg_idx_e    idx;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        known;
    pair_t       exp;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  aes_blk_if in_ch ();
  aes_blk_if out_ch ();
  aes_cfg_if cfg_ch ();

  aes128_block_encrypt_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  logic [7:0]  sub_lut [256];
  logic [7:0]  rc_lut [10];
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  pair_t       cipher_q[$];
  int          err_cnt;
  logic        stall_on;
  stim_row_t   rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("** aes128_block_encrypt_top: FAILED **");
    $finish;
  end

  function automatic logic [7:0] gmul2(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic pair_t encrypt_block(logic [63:0] kh, logic [63:0] kl,
                                          logic [63:0] ph, logic [63:0] pl);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  s [16];
    logic [7:0]  u [16];
    logic [7:0]  a0, a1, a2, a3, al;
    pair_t       res;
    w[0] = kh[63:32];
    w[1] = kh[31:0];
    w[2] = kl[63:32];
    w[3] = kl[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_lut[t[31:24]], sub_lut[t[23:16]], sub_lut[t[15:8]], sub_lut[t[7:0]]}
            ^ {rc_lut[i/4-1], 24'h0};
      end
      w[i] = w[i-4] ^ t;
    end
    for (int i = 0; i < 8; i++) begin
      s[i]   = ph[63-8*i -: 8];
      s[i+8] = pl[63-8*i -: 8];
    end
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            u[c*4+r] = sub_lut[s[((c+r)%4)*4+r]];
        s = u;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            s[c*4]   = a0 ^ al ^ gmul2(a0 ^ a1);
            s[c*4+1] = a1 ^ al ^ gmul2(a1 ^ a2);
            s[c*4+2] = a2 ^ al ^ gmul2(a2 ^ a3);
            s[c*4+3] = a3 ^ al ^ gmul2(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          s[c*4+r] ^= w[rnd*4+c][31-8*r -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[i+8];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // output side: random ready bursts, compare each transaction
  initial begin
    pair_t e;
    int    idle_cnt;
    idle_cnt = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_ch.data_high, 64'h0);
        end else begin
          e = cipher_q.pop_front();
          if (out_ch.data_high !== e.hi) report_mismatch("cipher_high", out_ch.data_high, e.hi);
          if (out_ch.data_low !== e.lo) report_mismatch("cipher_low", out_ch.data_low, e.lo);
        end
      end
      if (idle_cnt > 0 && stall_on) begin
        idle_cnt--;
        out_ch.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        idle_cnt = int'($urandom_range(1, 6)) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        idle_cnt = 0;
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_key(cfg_idx_e idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= 64'(idx);
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CfgKeyHigh) key_hi_q = val;
    else key_lo_q = val;
  endtask

  task automatic write_bad_index(logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= 64'd2 + 64'($urandom_range(0, 1000)) * 64'($urandom_range(0, 1));
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic send_block(logic [63:0] ph, logic [63:0] pl, logic known, pair_t exp);
    pair_t p;
    if (stall_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_high <= ph;
    in_ch.data_low  <= pl;
    do @(posedge clk_i); while (!in_ch.ready);
    p = encrypt_block(key_hi_q, key_lo_q, ph, pl);
    if (known && p !== exp) report_mismatch("directed table", p.hi, exp.hi);
    cipher_q.push_back(known ? exp : p);
  endtask

  task automatic add_row(logic is_key, cfg_idx_e idx, logic [63:0] hi, logic [63:0] lo,
                         logic known, pair_t exp);
    stim_row_t r;
    r.is_key = is_key; r.idx = idx; r.hi = hi; r.lo = lo; r.known = known; r.exp = exp;
    rows.push_back(r);
  endtask

  initial begin
    int ph;
    pair_t z;
    z = '0;
    for (int i = 0; i < 256; i++) sub_lut[i] = Sbox[i];
    for (int i = 0; i < 10; i++) rc_lut[i] = Rcon[i];
    err_cnt  = 0;
    key_hi_q = '0;
    key_lo_q = '0;
    stall_on = 1'b1;
    rst_ni   = 1'b0;
    in_ch.valid = 1'b0; in_ch.data_high = '0; in_ch.data_low = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;

    // zero key after reset, all-zero plaintext
    add_row(0, CfgKeyHigh, 64'h0, 64'h0, 1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    add_row(0, CfgKeyHigh, '1, '1, 0, z);
    add_row(0, CfgKeyHigh, 64'h8000000000000000, 64'h0, 0, z);
    add_row(0, CfgKeyHigh, 64'h0, 64'h1, 0, z);
    // standard test key
    add_row(1, CfgKeyHigh, 64'h2b7e151628aed2a6, 0, 0, z);
    add_row(1, CfgKeyLow, 64'habf7158809cf4f3c, 0, 0, z);
    add_row(0, CfgKeyHigh, 64'h3243f6a8885a308d, 64'h313198a2e0370734, 1,
            '{64'h3925841d02dc09fb, 64'hdc118597196a0b32});
    add_row(1, CfgKeyHigh, 64'h0001020304050607, 0, 0, z);
    add_row(1, CfgKeyLow, 64'h08090a0b0c0d0e0f, 0, 0, z);
    add_row(0, CfgKeyHigh, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
            '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    add_row(0, CfgKeyHigh, '1, 64'h0, 0, z);
    add_row(1, CfgKeyHigh, '1, 0, 0, z);
    add_row(1, CfgKeyLow, '1, 0, 0, z);
    add_row(0, CfgKeyHigh, '1, '1, 0, z);
    add_row(0, CfgKeyHigh, 64'h0, 64'h0, 0, z);
    add_row(0, CfgKeyHigh, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, z);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_key) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        write_key(rows[i].idx, rows[i].hi);
      end else begin
        send_block(rows[i].hi, rows[i].lo, rows[i].known, rows[i].exp);
      end
    end
    in_ch.valid <= 1'b0;
    wait_drained();
    write_bad_index(rand64());

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 250 == 0) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        ph = $urandom_range(0, 3);
        write_key(CfgKeyHigh, ph == 0 ? '0 : ph == 1 ? '1 : rand64());
        write_key(CfgKeyLow, ph == 0 ? '0 : ph == 1 ? '1 : rand64());
        if ($urandom_range(0, 1)) write_bad_index(rand64());
      end
      if (n >= NumRandom - 200) stall_on = 1'b0;
      send_block(rand64(), rand64(), 0, z);
    end
    in_ch.valid <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (err_cnt == 0 && cipher_q.size() == 0) begin
      $display("** aes128_block_encrypt_top: PASSED **");
    end else begin
      $display("** aes128_block_encrypt_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/aes_pkg.sv
design/aes_if.sv
design/aes_round.sv
design/aes128_block_encrypt_top.sv
verif/aes128_block_encrypt_top_tb.sv
